// ===== hw/rtl/deq_pkg.sv =====
package deq_pkg;

  // Ring geometry
  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // Word field widths
  localparam int KEY_W   = 32;
  localparam int MODE_W  = 3;
  localparam int COUNT_W = 5;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_BACK  = 3'd1,
    MODE_REM_FRONT = 3'd2,
    MODE_REM_BACK  = 3'd3,
    MODE_SUB       = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_ONE,
    ST_SUB_A,
    ST_SUB_B
  } state_t;

  // Memory request from the sequencer
  typedef struct packed {
    logic we;
    idx_t waddr;
    key_t wdata;
    logic re;
    idx_t raddr;
  } mem_req_t;

  // Finished result, valid for one cycle
  typedef struct packed {
    logic valid;
    key_t data;
    logic was_empty;
    logic was_full;
    cnt_t count;
  } result_t;

  // base + off modulo DEPTH; base < DEPTH and off <= DEPTH
  function automatic idx_t ring_add(idx_t base, cnt_t off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return IDX_W'(sum);
  endfunction

  function automatic idx_t ring_dec(idx_t base);
    return (base == '0) ? idx_t'(DEPTH - 1) : idx_t'(base - 1'b1);
  endfunction

  function automatic idx_t ring_inc(idx_t base);
    return ring_add(base, cnt_t'(1));
  endfunction

  // Slot of the key at the chosen end; count is nonzero
  function automatic idx_t take_addr(idx_t front, cnt_t count, logic from_back);
    return from_back ? ring_add(front, cnt_t'(count - 1'b1)) : front;
  endfunction

endpackage

// ===== hw/rtl/deq_if.sv =====
// Request channel: one operation per word
interface deq_req_if;
  logic                          valid;
  logic                          ready;
  logic [deq_pkg::MODE_W-1:0]    mode;
  logic signed [deq_pkg::KEY_W-1:0] key_in;
  logic                          first_from_back;
  logic                          second_from_back;

  modport source (output valid, mode, key_in, first_from_back, second_from_back,
                  input ready);
  modport sink   (input valid, mode, key_in, first_from_back, second_from_back,
                  output ready);
endinterface

// Response channel: one result per request
interface deq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [deq_pkg::KEY_W-1:0] data_out;
  logic                             was_empty;
  logic                             was_full;
  logic [deq_pkg::COUNT_W-1:0]      count_after;

  modport source (output valid, data_out, was_empty, was_full, count_after,
                  input ready);
  modport sink   (input valid, data_out, was_empty, was_full, count_after,
                  output ready);
endinterface

// ===== hw/rtl/deq_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle
module deq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/deq_ctrl.sv =====
// Sequencer: ring pointers, count, and the read-modify steps of each operation
module deq_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [deq_pkg::MODE_W-1:0] mode,
  input  deq_pkg::key_t            key_in,
  input  logic                     first_from_back,
  input  logic                     second_from_back,
  input  logic                     out_free,
  input  deq_pkg::key_t            rd_data,
  output deq_pkg::mem_req_t        mem_req,
  output deq_pkg::result_t         result
);

  deq_pkg::state_t state, state_next;
  deq_pkg::idx_t   front, front_next;
  deq_pkg::cnt_t   count, count_next;
  deq_pkg::key_t   minuend, minuend_next;
  logic            second_back, second_back_next;

  assign in_ready = (state == deq_pkg::ST_IDLE) && out_free;

  // State and pointer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= deq_pkg::ST_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
    end
  end

  // Subtract operands, no reset needed
  always_ff @(posedge clk) begin
    minuend     <= minuend_next;
    second_back <= second_back_next;
  end

  // Next state, memory requests and results
  always_comb begin
    state_next       = state;
    front_next       = front;
    count_next       = count;
    minuend_next     = minuend;
    second_back_next = second_back;
    mem_req          = '0;
    result           = '0;

    unique case (state)
      deq_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          second_back_next = second_from_back;
          unique case (deq_pkg::mode_t'(mode))
            deq_pkg::MODE_INS_FRONT, deq_pkg::MODE_INS_BACK: begin
              result.valid = 1'b1;
              if (count == deq_pkg::cnt_t'(deq_pkg::DEPTH)) begin
                result.was_full = 1'b1;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.wdata = key_in;
                if (deq_pkg::mode_t'(mode) == deq_pkg::MODE_INS_BACK) begin
                  mem_req.waddr = deq_pkg::ring_add(front, count);
                end else begin
                  mem_req.waddr = deq_pkg::ring_dec(front);
                  front_next    = deq_pkg::ring_dec(front);
                end
                count_next = count + 1'b1;
              end
              result.count = count_next;
            end
            deq_pkg::MODE_REM_FRONT, deq_pkg::MODE_REM_BACK: begin
              if (count == '0) begin
                result.valid     = 1'b1;
                result.was_empty = 1'b1;
                result.count     = count;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = deq_pkg::take_addr(front, count,
                                  deq_pkg::mode_t'(mode) == deq_pkg::MODE_REM_BACK);
                if (deq_pkg::mode_t'(mode) == deq_pkg::MODE_REM_FRONT) begin
                  front_next = deq_pkg::ring_inc(front);
                end
                count_next = count - 1'b1;
                state_next = deq_pkg::ST_RD_ONE;
              end
            end
            deq_pkg::MODE_SUB: begin
              if (count == '0) begin
                // both takes find the queue empty: 0 - 0
                result.valid     = 1'b1;
                result.was_empty = 1'b1;
                result.count     = count;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = deq_pkg::take_addr(front, count, first_from_back);
                if (!first_from_back) begin
                  front_next = deq_pkg::ring_inc(front);
                end
                count_next = count - 1'b1;
                state_next = deq_pkg::ST_SUB_A;
              end
            end
            default: begin
              // unused modes: no operation
              result.valid = 1'b1;
              result.count = count;
            end
          endcase
        end
      end

      deq_pkg::ST_RD_ONE: begin
        result.valid = 1'b1;
        result.data  = rd_data;
        result.count = count;
        state_next   = deq_pkg::ST_IDLE;
      end

      deq_pkg::ST_SUB_A: begin
        if (count == '0) begin
          // subtrahend reads 0
          result.valid     = 1'b1;
          result.data      = rd_data;
          result.was_empty = 1'b1;
          result.count     = count;
          state_next       = deq_pkg::ST_IDLE;
        end else begin
          minuend_next  = rd_data;
          mem_req.re    = 1'b1;
          mem_req.raddr = deq_pkg::take_addr(front, count, second_back);
          if (!second_back) begin
            front_next = deq_pkg::ring_inc(front);
          end
          count_next = count - 1'b1;
          state_next = deq_pkg::ST_SUB_B;
        end
      end

      deq_pkg::ST_SUB_B: begin
        result.valid = 1'b1;
        result.data  = minuend - rd_data;
        result.count = count;
        state_next   = deq_pkg::ST_IDLE;
      end

      default: begin
        state_next = deq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/double_ended_queue.sv =====
// Channel  Modport  Word fields
// req      sink     mode, key_in, first_from_back, second_from_back
// rsp      source   data_out, was_empty, was_full, count_after
//
// Insert, unused modes and any operation on an empty queue finish in ST_IDLE;
// remove adds ST_RD_ONE, subtract ST_SUB_A and ST_SUB_B (ST_SUB_A alone
// with one key held): each take reads the RAM's single, registered read port.
// The next word is taken when the sequencer is idle and the response
// register is empty or being drained; a stalled response blocks requests.
// Reset clears state, pointers, count and rsp_valid only, not the key RAM.
module double_ended_queue (
  input logic       clk,
  input logic       rst,
  deq_req_if.sink   req,
  deq_rsp_if.source rsp
);

  deq_pkg::mem_req_t mem_req;
  deq_pkg::result_t  result;
  logic [deq_pkg::KEY_W-1:0] rd_raw;
  deq_pkg::key_t     rd_data;
  logic              rsp_valid;
  logic              out_free;

  assign out_free = !rsp_valid || rsp.ready;
  assign rd_data  = deq_pkg::key_t'(rd_raw);

  deq_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (req.valid),
    .in_ready         (req.ready),
    .mode             (req.mode),
    .key_in           (req.key_in),
    .first_from_back  (req.first_from_back),
    .second_from_back (req.second_from_back),
    .out_free         (out_free),
    .rd_data          (rd_data),
    .mem_req          (mem_req),
    .result           (result)
  );

  deq_ram #(
    .DEPTH (deq_pkg::DEPTH),
    .WIDTH (deq_pkg::KEY_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rd_raw)
  );

  // Response register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (result.valid) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (result.valid) begin
      rsp.data_out    <= result.data;
      rsp.was_empty   <= result.was_empty;
      rsp.was_full    <= result.was_full;
      rsp.count_after <= deq_pkg::COUNT_W'(result.count);
    end
  end

  assign rsp.valid = rsp_valid;

endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  // Mode codes the block treats as no-ops
  localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  // Random phase flavors
  localparam int BIAS_FILL  = 0;
  localparam int BIAS_DRAIN = 1;
  localparam int BIAS_MIX   = 2;

  localparam int RAND_WORDS = 1950;
  localparam int DIR_ROWS   = 23;
  localparam int DRAIN_WAIT = 8;

  localparam key_t KEY_MAX = 32'sh7FFF_FFFF;
  localparam key_t KEY_MIN = 32'sh8000_0000;

  typedef struct {
    logic [MODE_W-1:0] mode;
    key_t              key;
    logic              first_back;
    logic              second_back;
  } deq_word_t;

  typedef struct {
    key_t               data;
    logic               was_empty;
    logic               was_full;
    logic [COUNT_W-1:0] count;
  } deq_rsp_t;

  typedef struct {
    logic [MODE_W-1:0] mode;
    key_t              key;
    logic              first_back;
    logic              second_back;
    int                reps;
    bit                typed;
    deq_rsp_t          known;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  deq_req_if req_ch ();
  deq_rsp_if rsp_ch ();

  double_ended_queue u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Directed words; known results only where they are obvious
  dir_row_t dir_tbl [DIR_ROWS] = '{
    '{MODE_REM_FRONT, 32'sd0,    1'b0, 1'b0, 1, 1'b1, '{32'sd0, 1'b1, 1'b0, 5'd0}},
    '{MODE_REM_BACK,  32'sd0,    1'b1, 1'b1, 1, 1'b1, '{32'sd0, 1'b1, 1'b0, 5'd0}},
    '{MODE_SUB,       32'sd0,    1'b1, 1'b0, 1, 1'b1, '{32'sd0, 1'b1, 1'b0, 5'd0}},
    '{MODE_SPARE_5,   KEY_MAX,   1'b1, 1'b1, 1, 1'b1, '{32'sd0, 1'b0, 1'b0, 5'd0}},
    '{MODE_INS_FRONT, KEY_MAX,   1'b0, 1'b0, 1, 1'b1, '{32'sd0, 1'b0, 1'b0, 5'd1}},
    '{MODE_INS_BACK,  KEY_MIN,   1'b1, 1'b1, 1, 1'b1, '{32'sd0, 1'b0, 1'b0, 5'd2}},
    '{MODE_SUB,       32'sd0,    1'b0, 1'b1, 1, 1'b1, '{-32'sd1, 1'b0, 1'b0, 5'd0}},
    '{MODE_INS_BACK,  -32'sd1,   1'b0, 1'b0, 1, 1'b1, '{32'sd0, 1'b0, 1'b0, 5'd1}},
    '{MODE_SUB,       32'sd0,    1'b1, 1'b1, 1, 1'b1, '{-32'sd1, 1'b1, 1'b0, 5'd0}},
    // fill to the brim, keys 1..16
    '{MODE_INS_BACK,  32'sd1,    1'b0, 1'b0, 16, 1'b0, '{32'sd0, 1'b0, 1'b0, 5'd0}},
    '{MODE_INS_FRONT, 32'sh5555_5555, 1'b0, 1'b0, 1, 1'b1,
      '{32'sd0, 1'b0, 1'b1, 5'd16}},
    '{MODE_INS_BACK,  32'shAAAA_AAAA, 1'b1, 1'b1, 1, 1'b1,
      '{32'sd0, 1'b0, 1'b1, 5'd16}},
    '{MODE_SPARE_6,   -32'sd1,   1'b0, 1'b1, 1, 1'b1, '{32'sd0, 1'b0, 1'b0, 5'd16}},
    '{MODE_REM_BACK,  32'sd0,    1'b0, 1'b0, 1, 1'b0, '{32'sd0, 1'b0, 1'b0, 5'd0}},
    '{MODE_REM_FRONT, 32'sd0,    1'b1, 1'b1, 1, 1'b0, '{32'sd0, 1'b0, 1'b0, 5'd0}},
    '{MODE_SUB,       32'sd0,    1'b0, 1'b0, 1, 1'b0, '{32'sd0, 1'b0, 1'b0, 5'd0}},
    '{MODE_SUB,       32'sd0,    1'b0, 1'b1, 1, 1'b0, '{32'sd0, 1'b0, 1'b0, 5'd0}},
    '{MODE_SUB,       32'sd0,    1'b1, 1'b0, 1, 1'b0, '{32'sd0, 1'b0, 1'b0, 5'd0}},
    '{MODE_SUB,       32'sd0,    1'b1, 1'b1, 1, 1'b0, '{32'sd0, 1'b0, 1'b0, 5'd0}},
    '{MODE_INS_FRONT, 32'sd0,    1'b0, 1'b0, 1, 1'b0, '{32'sd0, 1'b0, 1'b0, 5'd0}},
    '{MODE_INS_FRONT, KEY_MIN,   1'b1, 1'b0, 1, 1'b0, '{32'sd0, 1'b0, 1'b0, 5'd0}},
    '{MODE_SPARE_7,   KEY_MIN,   1'b1, 1'b1, 1, 1'b0, '{32'sd0, 1'b0, 1'b0, 5'd0}},
    // drain past empty
    '{MODE_REM_FRONT, 32'sd0,    1'b0, 1'b0, 10, 1'b0, '{32'sd0, 1'b0, 1'b0, 5'd0}}
  };

  // Deque shadow state
  key_t        ring_key [DEPTH];
  int unsigned ring_front = 0;
  int unsigned ring_cnt   = 0;
  logic        pop_found_empty;

  deq_rsp_t rsp_due [$];

  // Known result for the word currently on the bus
  bit       cur_typed;
  deq_rsp_t cur_known;

  bit quiet;
  int stall_left;
  int err_count;
  int n_checked;
  int n_full_hits;
  int n_empty_hits;
  int n_ins;
  int n_rem;
  int n_sub;
  int n_spare;

  deq_rsp_t got_rsp;
  deq_rsp_t want_rsp;

  function automatic key_t pop_end(bit from_back);
    key_t k;
    if (ring_cnt == 0) begin
      pop_found_empty = 1'b1;
      return '0;
    end
    if (from_back) begin
      k = ring_key[(ring_front + ring_cnt - 1) % DEPTH];
    end else begin
      k = ring_key[ring_front];
      ring_front = (ring_front + 1) % DEPTH;
    end
    ring_cnt--;
    return k;
  endfunction

  // Apply one word to the shadow deque and return its result
  function automatic deq_rsp_t deque_apply(deq_word_t w);
    deq_rsp_t r;
    key_t a;
    key_t b;
    r = '{data: '0, was_empty: 1'b0, was_full: 1'b0, count: '0};
    pop_found_empty = 1'b0;
    case (w.mode)
      MODE_INS_FRONT, MODE_INS_BACK: begin
        if (ring_cnt >= DEPTH) begin
          r.was_full = 1'b1;
        end else begin
          if (w.mode == MODE_INS_BACK) begin
            ring_key[(ring_front + ring_cnt) % DEPTH] = w.key;
          end else begin
            ring_front = (ring_front + DEPTH - 1) % DEPTH;
            ring_key[ring_front] = w.key;
          end
          ring_cnt++;
        end
      end
      MODE_REM_FRONT, MODE_REM_BACK: begin
        r.data = pop_end(w.mode == MODE_REM_BACK);
      end
      MODE_SUB: begin
        a = pop_end(w.first_back);
        b = pop_end(w.second_back);
        r.data = a - b;
      end
      default: ;
    endcase
    r.was_empty = pop_found_empty;
    r.count = COUNT_W'(ring_cnt);
    return r;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (quiet || r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Put one word on the request channel and wait for it to be taken
  task automatic send_word(deq_word_t w, bit typed, deq_rsp_t known);
    int gap;
    gap = pick_len();
    @(negedge clk);
    repeat (gap) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid            <= 1'b1;
    req_ch.mode             <= w.mode;
    req_ch.key_in           <= w.key;
    req_ch.first_from_back  <= w.first_back;
    req_ch.second_from_back <= w.second_back;
    cur_typed               <= typed;
    cur_known               <= known;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Response side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      stall_left   <= pick_len();
    end
  end

  // Check returned words, then predict for newly taken ones
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (rsp_due.size() == 0) begin
          err_count++;
          $display("%0t: result with none expected, expected nothing, actual data %h count %0d",
                   $time, rsp_ch.data_out, rsp_ch.count_after);
        end else begin
          want_rsp = rsp_due.pop_front();
          check_field("data_out", want_rsp.data, rsp_ch.data_out);
          check_field("was_empty", 32'(want_rsp.was_empty), 32'(rsp_ch.was_empty));
          check_field("was_full", 32'(want_rsp.was_full), 32'(rsp_ch.was_full));
          check_field("count_after", 32'(want_rsp.count), 32'(rsp_ch.count_after));
          n_checked++;
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        got_rsp = deque_apply('{req_ch.mode, req_ch.key_in,
                                req_ch.first_from_back, req_ch.second_from_back});
        if (got_rsp.was_full) n_full_hits++;
        if (got_rsp.was_empty) n_empty_hits++;
        case (req_ch.mode)
          MODE_INS_FRONT, MODE_INS_BACK: n_ins++;
          MODE_REM_FRONT, MODE_REM_BACK: n_rem++;
          MODE_SUB:                      n_sub++;
          default:                       n_spare++;
        endcase
        rsp_due.push_back(cur_typed ? cur_known : got_rsp);
      end
    end
  end

  // Stimulus
  initial begin
    deq_word_t w;
    deq_rsp_t  none;
    int n_sent;
    int phase_len;
    int bias;
    int ins_pct;
    int r;

    none = '{data: '0, was_empty: 1'b0, was_full: 1'b0, count: '0};
    req_ch.valid            = 1'b0;
    req_ch.mode             = MODE_INS_FRONT;
    req_ch.key_in           = '0;
    req_ch.first_from_back  = 1'b0;
    req_ch.second_from_back = 1'b0;
    rsp_ch.ready            = 1'b0;
    cur_typed               = 1'b0;
    cur_known               = none;
    quiet                   = 1'b0;
    stall_left              = 0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (dir_tbl[i]) begin
      for (int k = 0; k < dir_tbl[i].reps; k++) begin
        w = '{dir_tbl[i].mode, dir_tbl[i].key + key_t'(k),
              dir_tbl[i].first_back, dir_tbl[i].second_back};
        send_word(w, dir_tbl[i].typed, dir_tbl[i].known);
      end
    end

    // Random phases that lean toward filling, draining, or neither
    n_sent = 0;
    while (n_sent < RAND_WORDS) begin
      phase_len = $urandom_range(80, 20);
      bias      = $urandom_range(BIAS_MIX, BIAS_FILL);
      quiet     = ($urandom_range(3) == 0);
      ins_pct   = (bias == BIAS_FILL) ? 70 : (bias == BIAS_DRAIN) ? 25 : 48;
      repeat (phase_len) begin
        r = $urandom_range(99);
        if (r < 4) begin
          w.mode = $urandom_range(MODE_SPARE_7, MODE_SPARE_5);
        end else if (r < 4 + ins_pct) begin
          w.mode = $urandom_range(1) ? MODE_INS_BACK : MODE_INS_FRONT;
        end else if ($urandom_range(2) == 0) begin
          w.mode = MODE_SUB;
        end else begin
          w.mode = $urandom_range(1) ? MODE_REM_BACK : MODE_REM_FRONT;
        end
        if ($urandom_range(9) == 0) begin
          case ($urandom_range(3))
            0:       w.key = '0;
            1:       w.key = -32'sd1;
            2:       w.key = KEY_MIN;
            default: w.key = KEY_MAX;
          endcase
        end else begin
          w.key = $urandom;
        end
        w.first_back  = $urandom_range(1);
        w.second_back = $urandom_range(1);
        send_word(w, 1'b0, none);
        n_sent++;
      end
    end

    // Let the last results drain
    @(negedge clk);
    req_ch.valid <= 1'b0;
    quiet = 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d inserts, %0d removes, %0d subtracts, %0d no-op words; %0d results checked",
             n_ins, n_rem, n_sub, n_spare, n_checked);
    $display("Full queue hit %0d times, empty queue hit %0d times",
             n_full_hits, n_empty_hits);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("Timeout with %0d results outstanding", rsp_due.size());
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/deq_pkg.sv
hw/rtl/deq_if.sv
hw/rtl/deq_ram.sv
hw/rtl/deq_ctrl.sv
hw/rtl/double_ended_queue.sv
test/tb.sv
